### hdl/cpp_pkg.sv
// Shared types and constants of the centroid peak picker.
`timescale 1ns / 1ps
package cpp_pkg;
  localparam int WinDepth = 5;
  localparam int ApexSlot = 2;
  localparam int HalfWidthDefault = 2;
  localparam int MzW = 32;
  localparam int LvlW = 24;
  localparam int ProdW = MzW + LvlW;
  localparam int WsumW = ProdW + 3;
  localparam int TsumW = LvlW + 3;
  localparam int QueueDepth = 4;
  localparam logic [LvlW-1:0] ThreshReset = 24'd50;
  localparam logic [LvlW-1:0] RiseReset = 24'd50;
  localparam logic [0:0] RegAdmit = 1'b0;
  localparam logic [0:0] RegRise = 1'b1;

  typedef enum logic [1:0] {
    JOB_PEAK = 2'd0,
    JOB_END  = 2'd1
  } job_kind_t;

  // One job handed from the classifier to the centroid engine.
  typedef struct packed {
    job_kind_t               kind;
    logic [WinDepth*MzW-1:0] mz;
    logic [WinDepth*LvlW-1:0] lvl;
  } job_t;

  typedef struct packed {
    logic        peak_valid;
    logic [31:0] centroid_mz;
    logic [23:0] peak_intensity;
    logic        end_of_spectrum;
  } result_t;
endpackage

### hdl/cpp_if.sv
// Valid/ready channel interfaces for samples, results and register writes.
`timescale 1ns / 1ps
interface cpp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] mz_q16;
  logic [23:0] intensity;
  logic        last_of_spectrum;
  modport source(output valid, mz_q16, intensity, last_of_spectrum, input ready);
  modport sink(input valid, mz_q16, intensity, last_of_spectrum, output ready);
endinterface

interface cpp_out_if;
  logic        valid;
  logic        ready;
  logic        peak_valid;
  logic [31:0] centroid_mz;
  logic [23:0] peak_intensity;
  logic        end_of_spectrum;
  modport source(output valid, peak_valid, centroid_mz, peak_intensity, end_of_spectrum,
                 input ready);
  modport sink(input valid, peak_valid, centroid_mz, peak_intensity, end_of_spectrum,
               output ready);
endinterface

interface cpp_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [23:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### hdl/centroid_peak_picker.sv
// Top level of the centroid peak picker.
`timescale 1ns / 1ps
// An end marker passes from the queue through the engine's idle state straight to the output;
// a peak goes through one hand-off, five multiply/accumulate pairs, a 59-step restoring divider, out.
// Throughput: one sample per cycle while the four-deep job queue has room; the
// centroid engine takes no new job until its last result has been accepted.
// Reset (rst_n, synchronous, active low) clears the window, the queue and the
// engine, and sets both thresholds to 50.
module centroid_peak_picker #(
  parameter int HALF_WIDTH = cpp_pkg::HalfWidthDefault
) (
  input  logic clk,
  input  logic rst_n,
  cpp_in_if.sink    in_ch,
  cpp_out_if.source out_ch,
  cpp_cfg_if.sink   cfg_ch
);
  // Register file: writes are always taken.
  logic [cpp_pkg::LvlW-1:0] thresh_r, rise_r;
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= cpp_pkg::ThreshReset;
      rise_r   <= cpp_pkg::RiseReset;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        cpp_pkg::RegAdmit: thresh_r <= cfg_ch.data;
        cpp_pkg::RegRise:  rise_r   <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Front end to queue, queue to centroid engine: each beat is one job.
  logic fq_valid, fq_ready, qb_valid, qb_ready;
  cpp_pkg::job_t fq_job, qb_job;
  cpp_pkg::result_t res;

  cpp_front u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_mz(in_ch.mz_q16), .in_lvl(in_ch.intensity), .in_last(in_ch.last_of_spectrum),
    .thresh(thresh_r), .rise(rise_r),
    .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
  );

  cpp_queue #(.Depth(cpp_pkg::QueueDepth)) u_queue (
    .clk, .rst_n,
    .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_job),
    .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_job)
  );

  cpp_back #(.HalfWidth(HALF_WIDTH)) u_back (
    .clk, .rst_n,
    .job_valid(qb_valid), .job_ready(qb_ready), .job(qb_job),
    .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res(res)
  );

  assign out_ch.peak_valid      = res.peak_valid;
  assign out_ch.centroid_mz     = res.centroid_mz;
  assign out_ch.peak_intensity  = res.peak_intensity;
  assign out_ch.end_of_spectrum = res.end_of_spectrum;
endmodule

### hdl/cpp_front.sv
// Front end: admits samples, keeps the window and tests the apex.
`timescale 1ns / 1ps
module cpp_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [31:0]                in_mz,
  input  logic [23:0]                in_lvl,
  input  logic                       in_last,
  input  logic [cpp_pkg::LvlW-1:0]   thresh,
  input  logic [cpp_pkg::LvlW-1:0]   rise,
  output logic                       job_valid,
  input  logic                       job_ready,
  output cpp_pkg::job_t              job
);
  logic [cpp_pkg::MzW-1:0]  mz_r  [cpp_pkg::WinDepth];
  logic [cpp_pkg::LvlW-1:0] lvl_r [cpp_pkg::WinDepth];
  logic [2:0] cnt_r;
  logic [cpp_pkg::MzW-1:0]  mz_n  [cpp_pkg::WinDepth];
  logic [cpp_pkg::LvlW-1:0] lvl_n [cpp_pkg::WinDepth];
  logic [2:0] cnt_n;
  logic       acc, keep, concave;
  logic [cpp_pkg::LvlW:0] r1, r0;

  assign in_ready = job_ready;
  assign acc  = in_valid && in_ready;
  assign keep = !in_last && (in_lvl >= thresh);

  always_comb begin
    for (int k = 0; k < cpp_pkg::WinDepth - 1; k++) begin
      mz_n[k]  = mz_r[k+1];
      lvl_n[k] = lvl_r[k+1];
    end
    mz_n[cpp_pkg::WinDepth-1]  = in_mz;
    lvl_n[cpp_pkg::WinDepth-1] = in_lvl;
    cnt_n = (cnt_r < 3'(cpp_pkg::WinDepth)) ? cnt_r + 3'd1 : cnt_r;
  end

  assign r1 = {1'b0, lvl_n[1]} + {1'b0, rise};
  assign r0 = {1'b0, lvl_n[0]} + {1'b0, rise};
  assign concave = (lvl_n[2] > rise) && ({1'b0, lvl_n[2]} > r1) && (lvl_n[2] >= lvl_n[3])
                && ({1'b0, lvl_n[1]} > r0) && (lvl_n[3] >= lvl_n[4]);

  always_comb begin
    job_valid = acc && (in_last || (keep && cnt_n == 3'(cpp_pkg::WinDepth) && concave));
    job.kind  = in_last ? cpp_pkg::JOB_END : cpp_pkg::JOB_PEAK;
    for (int k = 0; k < cpp_pkg::WinDepth; k++) begin
      job.mz[k*cpp_pkg::MzW +: cpp_pkg::MzW]    = mz_n[k];
      job.lvl[k*cpp_pkg::LvlW +: cpp_pkg::LvlW] = lvl_n[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (acc && in_last)) begin
      cnt_r <= '0;
      for (int k = 0; k < cpp_pkg::WinDepth; k++) begin
        mz_r[k] <= '0;
        lvl_r[k] <= '0;
      end
    end else if (acc && keep) begin
      cnt_r <= cnt_n;
      for (int k = 0; k < cpp_pkg::WinDepth; k++) begin
        mz_r[k] <= mz_n[k];
        lvl_r[k] <= lvl_n[k];
      end
    end
  end

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'(cpp_pkg::WinDepth)) else $error("kept count overflow");
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_last |=> cnt_r == 3'd0) else $error("window not cleared");
  a_peak_full: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid && job.kind == cpp_pkg::JOB_PEAK |=> cnt_r == 3'(cpp_pkg::WinDepth))
    else $error("peak from short window");
endmodule

### hdl/cpp_queue.sv
// Small job queue between the front end and the centroid engine.
`timescale 1ns / 1ps
module cpp_queue #(
  parameter int Depth = cpp_pkg::QueueDepth
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  cpp_pkg::job_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output cpp_pkg::job_t rd_data
);
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  cpp_pkg::job_t mem_r [Depth];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic wr, rd;

  assign wr_ready = cnt_r != (AW+1)'(Depth);
  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= (wp_r == AW'(Depth-1)) ? '0 : wp_r + 1'b1;
      if (rd) rp_r <= (rp_r == AW'(Depth-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(Depth)) else $error("queue overflow");
endmodule

### hdl/cpp_back.sv
// Back end: weighted sums and a restoring divider for the centroid.
`timescale 1ns / 1ps
module cpp_back #(
  parameter int HalfWidth = cpp_pkg::HalfWidthDefault
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             job_valid,
  output logic             job_ready,
  input  cpp_pkg::job_t    job,
  output logic             res_valid,
  input  logic             res_ready,
  output cpp_pkg::result_t res
);
  localparam int Taps = 2*HalfWidth + 1;
  localparam int WW = cpp_pkg::WsumW;
  localparam int TW = cpp_pkg::TsumW;

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_SUM, S_DIV, S_OUT} st_t;
  st_t st_r;
  cpp_pkg::job_t job_r;
  logic [2:0]    tap_r;
  logic [cpp_pkg::ProdW-1:0] prod_r;
  logic [TW-1:0] lsum_r;
  logic [WW-1:0] wsum_r;
  logic [WW-1:0] quo_r;
  logic [TW:0]   rem_r;
  logic [5:0]    bit_r;
  cpp_pkg::result_t res_r;
  logic [2:0]  slot;
  logic [31:0] cur_mz;
  logic [23:0] cur_lvl;
  logic [TW:0] trial;
  logic        ge;

  assign slot    = 3'(cpp_pkg::ApexSlot - HalfWidth) + tap_r;
  assign cur_mz  = job_r.mz[slot*cpp_pkg::MzW +: cpp_pkg::MzW];
  assign cur_lvl = job_r.lvl[slot*cpp_pkg::LvlW +: cpp_pkg::LvlW];
  assign trial   = {rem_r[TW-1:0], quo_r[WW-1]};
  assign ge      = trial >= {1'b0, lsum_r};
  assign job_ready = (st_r == S_IDLE);
  assign res_valid = (st_r == S_OUT);
  assign res = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      unique case (st_r)
        S_IDLE: begin
          if (job_valid) begin
            job_r  <= job;
            tap_r  <= '0;
            wsum_r <= '0;
            lsum_r <= '0;
            if (job.kind == cpp_pkg::JOB_END) begin
              res_r <= '{peak_valid: 1'b0, centroid_mz: '0, peak_intensity: '0,
                         end_of_spectrum: 1'b1};
              st_r <= S_OUT;
            end else begin
              st_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod_r <= cur_mz * cur_lvl;
          lsum_r <= lsum_r + TW'(cur_lvl);
          st_r <= S_SUM;
        end
        S_SUM: begin
          wsum_r <= wsum_r + WW'(prod_r);
          if (tap_r == 3'(Taps-1)) begin
            quo_r <= wsum_r + WW'(prod_r);
            rem_r <= '0;
            bit_r <= 6'(WW);
            st_r <= S_DIV;
          end else begin
            tap_r <= tap_r + 3'd1;
            st_r <= S_MUL;
          end
        end
        S_DIV: begin
          rem_r <= ge ? trial - {1'b0, lsum_r} : trial;
          quo_r <= {quo_r[WW-2:0], ge};
          bit_r <= bit_r - 6'd1;
          if (bit_r == 6'd1) begin
            res_r <= '{peak_valid: 1'b1,
                       centroid_mz: (lsum_r == '0) ? 32'd0 : {quo_r[30:0], ge},
                       peak_intensity: job_r.lvl[cpp_pkg::ApexSlot*cpp_pkg::LvlW +:
                                                 cpp_pkg::LvlW],
                       end_of_spectrum: 1'b0};
            st_r <= S_OUT;
          end
        end
        S_OUT: if (res_ready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_ready |=> res_valid && $stable(res)) else $error("result dropped");
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> res.peak_valid != res.end_of_spectrum) else $error("bad result kind");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_DIV |-> !job_ready) else $error("accepted while busy");
endmodule
